FILE: src/bss_pkg.sv
// Package for the byte stream substring search: sizes, types, register codes, helpers.
`default_nettype none
package bss_pkg;

  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned CMP_W       = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int unsigned LANE_W      = $clog2(MAX_PATTERN);
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0]             byte_t;
  typedef logic [4:0]             len_t;
  typedef logic [31:0]            lim_t;
  typedef logic [31:0]            total_t;
  typedef logic [63:0]            word_t;
  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [OFFSET_BITS:0]   offp_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [LANE_W-1:0]      lane_t;
  typedef logic [FIFO_PTR_W-1:0]  fptr_t;
  typedef logic [FIFO_CNT_W-1:0]  fcnt_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_SEARCH_LIMIT   = 3'd3,
    CFG_REPORT_ALL     = 3'd4
  } cfg_reg_e;

  // Result kinds.
  localparam logic KIND_MATCH  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    byte_t data_byte;
    logic  end_of_stream;
  } in_t;

  typedef struct packed {
    logic   result_kind;
    total_t match_offset;
    total_t match_total;
    logic   last_result;
  } out_t;

  // Pattern byte k from the two packed pattern words.
  function automatic byte_t pat_byte(word_t lo, word_t hi, logic [3:0] k);
    word_t w;
    w = k[3] ? hi : lo;
    return w[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: src/bss_cell.sv
// One window cell: holds a stream byte, passes it on, and compares it to its pattern byte.
`default_nettype none
module bss_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           shift_i,
  input  wire logic           clear_i,
  input  wire bss_pkg::byte_t byte_i,
  input  wire bss_pkg::byte_t pat_i,
  input  wire logic           en_i,
  output bss_pkg::byte_t      byte_o,
  output logic                match_o
);

  bss_pkg::byte_t byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // a lane past the pattern length always agrees
  assign match_o = !en_i || (byte_q == pat_i);
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

FILE: src/bss_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
`default_nettype none
module bss_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push0_i,
  input  wire logic          push1_i,
  input  wire bss_pkg::out_t data0_i,
  input  wire bss_pkg::out_t data1_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bss_pkg::out_t      out_data_o
);

  bss_pkg::out_t mem_q [bss_pkg::FIFO_DEPTH];
  bss_pkg::fptr_t wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  bss_pkg::fcnt_t count_q, count_d;
  logic pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= bss_pkg::fcnt_t'(bss_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + bss_pkg::fptr_t'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push0_i && push1_i) begin
      wr_ptr_d = wr_ptr_q + bss_pkg::fptr_t'(2);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = pop ? rd_ptr_q + bss_pkg::fptr_t'(1) : rd_ptr_q;
    count_d  = count_q + bss_pkg::fcnt_t'(push0_i) + bss_pkg::fcnt_t'(push1_i)
             - bss_pkg::fcnt_t'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/byte_stream_substring_search.sv
// Top level of the byte stream substring search.
// Result beats are written into the result queue as their byte beat is taken.
// Throughput: one byte per cycle while the result queue has room; a final byte
//   ending a match gives two result beats, both pushed into the four-entry queue.
// Reset: asynchronous, active low; clears window, offsets, counters and registers
//   at once, except report_all, which resets to one. No clearing pass.
`default_nettype none
module byte_stream_substring_search (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // byte channel
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bss_pkg::in_t   in_data_i,
  // result channel
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bss_pkg::out_t       out_data_o,
  // configuration write port
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire bss_pkg::word_t cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  bss_pkg::word_t pat_lo_q, pat_hi_q;
  bss_pkg::len_t  pat_len_q;
  bss_pkg::lim_t  limit_q;
  logic           report_all_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q     <= '0;
      pat_hi_q     <= '0;
      pat_len_q    <= '0;
      limit_q      <= '0;
      report_all_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bss_pkg::CFG_PATTERN_LOW:    pat_lo_q     <= cfg_wdata_i;
        bss_pkg::CFG_PATTERN_HIGH:   pat_hi_q     <= cfg_wdata_i;
        bss_pkg::CFG_PATTERN_LENGTH: pat_len_q    <= cfg_wdata_i[4:0];
        bss_pkg::CFG_SEARCH_LIMIT:   limit_q      <= cfg_wdata_i[31:0];
        bss_pkg::CFG_REPORT_ALL:     report_all_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic fifo_room, accept, eos;
  assign in_ready_o = fifo_room;
  assign accept     = in_valid_i && in_ready_o;
  assign eos        = in_data_i.end_of_stream;

  // ---------------------------------------------------------------------------
  // Window: lane 0 is the incoming byte, lane j (j >= 1) is the byte j beats
  // older, held in cell j. Lane j is checked against pattern byte len-1-j, so
  // the whole window compare is one parallel AND across the lanes.
  // ---------------------------------------------------------------------------
  bss_pkg::byte_t chain [bss_pkg::MAX_PATTERN];
  logic [bss_pkg::MAX_PATTERN-1:0] lane_match;
  logic [bss_pkg::MAX_PATTERN-1:0] lane_en;
  bss_pkg::byte_t lane_pat [bss_pkg::MAX_PATTERN];

  assign chain[0] = in_data_i.data_byte;

  for (genvar j = 0; j < bss_pkg::MAX_PATTERN; j++) begin : g_lane
    bss_pkg::len_t pidx;
    assign lane_en[j]  = (bss_pkg::len_t'(j) < pat_len_q);
    assign pidx        = pat_len_q - bss_pkg::len_t'(j + 1);
    assign lane_pat[j] = bss_pkg::pat_byte(pat_lo_q, pat_hi_q, pidx[3:0]);

    if (j == 0) begin : g_head
      assign lane_match[j] = !lane_en[j] || (chain[0] == lane_pat[j]);
    end else begin : g_cell
      bss_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .clear_i (eos),
        .byte_i  (chain[j-1]),
        .pat_i   (lane_pat[j]),
        .en_i    (lane_en[j]),
        .byte_o  (chain[j]),
        .match_o (lane_match[j])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stream state and match decision
  // ---------------------------------------------------------------------------
  bss_pkg::off_t   offset_q, offset_d, earliest_q, earliest_d;
  bss_pkg::total_t total_q, total_d, total_inc;
  logic            first_rep_q, first_rep_d;

  bss_pkg::offp_t cur_p1;
  bss_pkg::off_t  start, next_sat;
  logic len_ok, hist_ok, lim_ok, mode_ok, start_ok, hit;

  assign cur_p1   = bss_pkg::offp_t'(offset_q) + bss_pkg::offp_t'(1);
  // start = cur + 1 - len; only used when cur + 1 >= len
  assign start    = bss_pkg::off_t'(cur_p1 - bss_pkg::offp_t'(pat_len_q));
  // start + len == cur + 1, saturated at the top offset
  assign next_sat = cur_p1[bss_pkg::OFFSET_BITS] ? '1
                                                 : cur_p1[bss_pkg::OFFSET_BITS-1:0];

  assign len_ok   = (pat_len_q != '0) &&
                    (pat_len_q <= bss_pkg::len_t'(bss_pkg::MAX_PATTERN));
  assign hist_ok  = (cur_p1 >= bss_pkg::offp_t'(pat_len_q));
  assign lim_ok   = (limit_q == '0) ||
                    (bss_pkg::cmp_t'(offset_q) < bss_pkg::cmp_t'(limit_q));
  assign mode_ok  = report_all_q || !first_rep_q;
  assign start_ok = (start >= earliest_q);
  assign hit      = len_ok && hist_ok && lim_ok && mode_ok && start_ok && (&lane_match);

  assign total_inc = (total_q != '1) ? total_q + bss_pkg::total_t'(1) : total_q;

  always_comb begin
    offset_d    = offset_q;
    earliest_d  = earliest_q;
    total_d     = total_q;
    first_rep_d = first_rep_q;
    if (accept) begin
      if (eos) begin
        // stream ends: back to the reset state
        offset_d    = '0;
        earliest_d  = '0;
        total_d     = '0;
        first_rep_d = 1'b0;
      end else begin
        offset_d = next_sat;
        if (hit) begin
          earliest_d = next_sat;
          total_d    = total_inc;
          if (!report_all_q) begin
            first_rep_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      earliest_q  <= '0;
      total_q     <= '0;
      first_rep_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      earliest_q  <= earliest_d;
      total_q     <= total_d;
      first_rep_q <= first_rep_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Results: match beat first, finish beat after it on the final byte
  // ---------------------------------------------------------------------------
  bss_pkg::out_t match_res, fin_res, data0;
  bss_pkg::total_t total_now;
  logic push0, push1;

  assign total_now = hit ? total_inc : total_q;

  always_comb begin
    match_res.result_kind  = bss_pkg::KIND_MATCH;
    match_res.match_offset = bss_pkg::total_t'(bss_pkg::cmp_t'(start));
    match_res.match_total  = total_now;
    match_res.last_result  = !eos;

    fin_res.result_kind    = bss_pkg::KIND_FINISH;
    fin_res.match_offset   = '0;
    fin_res.match_total    = total_now;
    fin_res.last_result    = 1'b1;
  end

  assign push0 = accept && (hit || eos);
  assign push1 = accept && hit && eos;
  assign data0 = hit ? match_res : fin_res;

  bss_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .push1_i     (push1),
    .data0_i     (data0),
    .data1_i     (fin_res),
    .room_o      (fifo_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: test/tb_byte_stream_substring_search.sv
`timescale 1ns / 1ps
// Testbench for byte_stream_substring_search: directed table, then random streams against a predictor.
module tb_byte_stream_substring_search;

  localparam int unsigned GAP_MAX   = 14;        // longest idle stretch per beat, either side
  localparam int unsigned PHASES    = 10;        // random settings phases
  localparam int unsigned PHASE_LEN = 145;       // minimum bytes per random phase
  localparam int unsigned HOLD_AT   = 400;       // byte count that triggers the long receiver stall
  localparam int unsigned HOLD_LEN  = 150;       // cycles of that stall
  localparam int unsigned SETTLE    = 3;         // quiet cycles after draining
  localparam int unsigned SHOW_MAX  = 10;        // mismatches printed in full
  localparam logic [32:0] OFF_MAX   = 33'h0_FFFF_FFFF;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} gap_mode_e;

  // Hand-written expectation for one byte beat; when on, it replaces the predictor's output.
  typedef struct packed {
    logic          on;
    logic [1:0]    count;
    bss_pkg::out_t first;
    bss_pkg::out_t second;
  } pin_t;

  // One line of the directed table: either a register write or a byte beat.
  typedef struct packed {
    row_kind_e         kind;
    bss_pkg::cfg_reg_e idx;
    bss_pkg::word_t    value;
    bss_pkg::in_t      beat;
    pin_t              pin;
  } row_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i;
  logic           in_ready_o;
  bss_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  bss_pkg::out_t  out_data_o;
  logic           cfg_we_i;
  logic [2:0]     cfg_idx_i;
  bss_pkg::word_t cfg_wdata_i;

  byte_stream_substring_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the registers, at their reset values.
  bss_pkg::word_t pat_lo_q  = '0;
  bss_pkg::word_t pat_hi_q  = '0;
  bss_pkg::len_t  pat_len_q = '0;
  bss_pkg::lim_t  limit_q   = '0;
  logic           all_q     = 1'b1;

  // Search state of the predictor: window newest first, offsets, count, first-only latch.
  bss_pkg::byte_t  window [bss_pkg::MAX_PATTERN] = '{default: 8'h00};
  bss_pkg::off_t   scan_off   = '0;
  bss_pkg::off_t   next_start = '0;
  bss_pkg::total_t found      = '0;
  logic            first_done = 1'b0;

  bss_pkg::out_t fresh_q[$];      // results of the byte just predicted
  bss_pkg::out_t results_due[$];  // results still to come out, oldest first
  pin_t          pin_q[$];        // one entry per byte beat offered, in order
  row_t          directed[$];
  int            errors      = 0;
  int            bytes_taken = 0;
  gap_mode_e     tx_mode     = GAPS_FULL;
  gap_mode_e     rx_mode     = GAPS_FULL;
  logic          hold_off;
  int unsigned   rx_gap;

  function automatic bss_pkg::out_t res(logic kind, bss_pkg::total_t off,
                                        bss_pkg::total_t tot, logic last);
    bss_pkg::out_t r;
    r.result_kind  = kind;
    r.match_offset = off;
    r.match_total  = tot;
    r.last_result  = last;
    return r;
  endfunction

  function automatic row_t cfg_row(bss_pkg::cfg_reg_e idx, bss_pkg::word_t value);
    row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t byte_row(bss_pkg::byte_t data, logic eos, logic pinned,
                                    logic [1:0] count, bss_pkg::out_t first,
                                    bss_pkg::out_t second);
    row_t r;
    r                      = '0;
    r.kind                 = ROW_BYTE;
    r.beat.data_byte       = data;
    r.beat.end_of_stream   = eos;
    r.pin.on               = pinned;
    r.pin.count            = count;
    r.pin.first            = first;
    r.pin.second           = second;
    return r;
  endfunction

  function automatic int unsigned draw_gap(gap_mode_e mode);
    case (mode)
      GAPS_NONE: return 0;
      GAPS_FULL: return $urandom_range(0, GAP_MAX);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
    endcase
  endfunction

  // Pattern byte k sits at bits 8k+7..8k of {high, low}; compare against the window,
  // where the pattern's last byte is the newest one.
  function automatic logic window_hit(int unsigned len);
    logic [127:0] pat;
    pat = {pat_hi_q, pat_lo_q};
    for (int k = 0; k < len; k++)
      if (window[len-1-k] !== pat[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // One byte through the search: shift window, try a match ending here, then the finish beat.
  task automatic search_step(bss_pkg::in_t beat);
    logic [32:0] cur;
    logic [32:0] start;
    logic [32:0] stop;
    int unsigned len;
    logic        hit;
    fresh_q.delete();
    cur   = {1'b0, scan_off};
    len   = pat_len_q;
    hit   = 1'b0;
    start = '0;
    for (int k = bss_pkg::MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = beat.data_byte;
    // length 0 or above 16 never matches; too little history, past the limit,
    // or first-only mode already done: no match either
    if (len >= 1 && len <= bss_pkg::MAX_PATTERN && cur + 1 >= len
        && (limit_q == 0 || cur < {1'b0, limit_q}) && (all_q || !first_done)) begin
      start = cur + 1 - len;
      hit   = (start >= {1'b0, next_start}) && window_hit(len);
    end
    if (hit) begin
      stop       = start + len;
      next_start = (stop > OFF_MAX) ? OFF_MAX[31:0] : stop[31:0];  // no overlap
      if (found != '1) found = found + 1;                          // saturating
      if (!all_q) first_done = 1'b1;
      fresh_q = {fresh_q, res(bss_pkg::KIND_MATCH, start[31:0], found,
                              !beat.end_of_stream)};
    end
    if (scan_off != '1) scan_off = scan_off + 1;
    if (beat.end_of_stream) begin
      fresh_q    = {fresh_q, res(bss_pkg::KIND_FINISH, 32'd0, found, 1'b1)};
      window     = '{default: 8'h00};
      scan_off   = '0;
      next_start = '0;
      found      = '0;
      first_done = 1'b0;
    end
  endtask

  // Monitor: predict on every byte beat taken, check every result beat taken.
  // Everything is sampled at the edge, before any nonblocking update lands.
  always @(posedge clk_i) begin : monitor
    pin_t          pin;
    bss_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        search_step(in_data_i);
        pin = pin_q.pop_front();
        bytes_taken++;
        if (!pin.on) begin
          results_due = {results_due, fresh_q};
        end else begin
          if (pin.count >= 1) results_due = {results_due, pin.first};
          if (pin.count == 2) results_due = {results_due, pin.second};
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("unexpected result beat: kind %0d offset %0d total %0d last %0d",
                     out_data_o.result_kind, out_data_o.match_offset,
                     out_data_o.match_total, out_data_o.last_result);
        end else begin
          want = results_due.pop_front();
          if (out_data_o.result_kind !== want.result_kind
              || out_data_o.match_offset !== want.match_offset
              || out_data_o.match_total !== want.match_total
              || out_data_o.last_result !== want.last_result) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display({"result mismatch: expected kind %0d offset %0d total %0d last %0d,",
                        " got kind %0d offset %0d total %0d last %0d"},
                       want.result_kind, want.match_offset, want.match_total,
                       want.last_result, out_data_o.result_kind, out_data_o.match_offset,
                       out_data_o.match_total, out_data_o.last_result);
          end
        end
      end
    end
  end

  // Receiver: after each result beat taken, ready drops for a drawn number of cycles.
  // hold_off forces it low on top of that.
  initial begin : receiver
    rx_gap      = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) rx_gap = draw_gap(rx_mode);
      else if (rx_gap != 0) rx_gap--;
      out_ready_i <= (rx_gap == 0) && !hold_off;
    end
  end

  // One long receiver stall in the random part; the sender keeps going, so the
  // result queue fills and the byte side has to back off.
  initial begin : hold_off_burst
    hold_off = 1'b0;
    wait (bytes_taken >= HOLD_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_byte_stream_substring_search: done, errors");
    $finish;
  end

  // Called at an edge: optional idle gap, then valid held until the beat is taken.
  // Valid is left high on return, so with no gap a back-to-back beat keeps valid high.
  task automatic send_byte(bss_pkg::in_t beat, pin_t pin);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (cfg_we_i) cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin_q      = {pin_q, pin};
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic feed_byte(bss_pkg::byte_t data);
    bss_pkg::in_t beat;
    beat.data_byte     = data;
    beat.end_of_stream = ($urandom_range(0, 39) == 0);
    send_byte(beat, '0);
  endtask

  // Register write; the shadow moves now, the block at the next edge. Only used while idle.
  task automatic write_reg(bss_pkg::cfg_reg_e idx, bss_pkg::word_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      bss_pkg::CFG_PATTERN_LOW:    pat_lo_q  = value;
      bss_pkg::CFG_PATTERN_HIGH:   pat_hi_q  = value;
      bss_pkg::CFG_PATTERN_LENGTH: pat_len_q = value[4:0];
      bss_pkg::CFG_SEARCH_LIMIT:   limit_q   = value[31:0];
      bss_pkg::CFG_REPORT_ALL:     all_q     = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop offering, wait for every expected result, then a few quiet cycles for a
  // byte that causes nothing to clear the pipe.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    row_t           row;
    logic           idle;
    bss_pkg::byte_t alpha [3];
    logic [127:0]   pat_bytes;
    int unsigned    len;
    int unsigned    pick;
    int unsigned    run;
    int unsigned    sent;
    bss_pkg::lim_t  limit;

    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;

    // --- directed table ---
    // after reset the length is zero: nothing matches, only the finish beat
    directed = {directed, byte_row(8'hFF, 1'b1, 1'b1, 2'd1,
                                   res(bss_pkg::KIND_FINISH, 32'd0, 32'd0, 1'b1), '0)};
    // oversized length: all-zero window vs all-zero pattern still gives no match
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LENGTH, 64'd31)};
    directed = {directed, byte_row(8'h00, 1'b1, 1'b1, 2'd1,
                                   res(bss_pkg::KIND_FINISH, 32'd0, 32'd0, 1'b1), '0)};
    // widest pattern, all ones, widest limit; short history keeps 15 bytes quiet
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LOW, '1)};
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_HIGH, '1)};
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LENGTH, 64'd16)};
    directed = {directed, cfg_row(bss_pkg::CFG_SEARCH_LIMIT, 64'h0000_0000_FFFF_FFFF)};
    for (int k = 0; k < 15; k++)
      directed = {directed, byte_row(8'hFF, 1'b0, 1'b0, 2'd0, '0, '0)};
    // match on the final byte: match beat not last, then the finish
    directed = {directed, byte_row(8'hFF, 1'b1, 1'b1, 2'd2,
                                   res(bss_pkg::KIND_MATCH, 32'd0, 32'd1, 1'b0),
                                   res(bss_pkg::KIND_FINISH, 32'd0, 32'd1, 1'b1))};
    // first-only mode, limit of two bytes; report_all flips mid-stream
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LOW, 64'd0)};
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LENGTH, 64'd1)};
    directed = {directed, cfg_row(bss_pkg::CFG_REPORT_ALL, 64'd0)};
    directed = {directed, cfg_row(bss_pkg::CFG_SEARCH_LIMIT, 64'd2)};
    directed = {directed, byte_row(8'h00, 1'b0, 1'b1, 2'd1,
                                   res(bss_pkg::KIND_MATCH, 32'd0, 32'd1, 1'b1), '0)};
    directed = {directed, byte_row(8'h00, 1'b0, 1'b1, 2'd0, '0, '0)};
    directed = {directed, cfg_row(bss_pkg::CFG_REPORT_ALL, 64'd1)};
    directed = {directed, byte_row(8'h00, 1'b0, 1'b0, 2'd0, '0, '0)};   // past the limit
    directed = {directed, byte_row(8'h00, 1'b1, 1'b1, 2'd1,
                                   res(bss_pkg::KIND_FINISH, 32'd0, 32'd1, 1'b1), '0)};
    // sliding compare: "aab" found one byte in, inside "aaab"
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LOW, 64'h62_61_61)};
    directed = {directed, cfg_row(bss_pkg::CFG_PATTERN_LENGTH, 64'd3)};
    directed = {directed, cfg_row(bss_pkg::CFG_SEARCH_LIMIT, 64'd0)};
    for (int k = 0; k < 3; k++)
      directed = {directed, byte_row(8'h61, 1'b0, 1'b0, 2'd0, '0, '0)};
    directed = {directed, byte_row(8'h62, 1'b1, 1'b0, 2'd0, '0, '0)};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle = 1'b1;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        if (!idle) settle();
        write_reg(row.idx, row.value);
        idle = 1'b1;
      end else begin
        send_byte(row.beat, row.pin);
        idle = 1'b0;
      end
    end

    // --- random phases ---
    // Each phase: fresh settings (streams run on across phases, so this also
    // changes registers mid-stream), a small alphabet so the window hits often,
    // mostly whole or cut-off copies of the pattern plus noise.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      tx_mode = gap_mode_e'($urandom_range(0, 2));
      rx_mode = gap_mode_e'($urandom_range(0, 2));
      for (int a = 0; a < 3; a++) alpha[a] = bss_pkg::byte_t'($urandom_range(0, 255));

      pick = $urandom_range(0, 19);
      if (pick == 0)      len = 0;
      else if (pick == 1) len = 16;
      else if (pick == 2) len = $urandom_range(17, 31);
      else if (pick < 7)  len = $urandom_range(7, 15);
      else                len = $urandom_range(1, 6);
      for (int k = 0; k < bss_pkg::MAX_PATTERN; k++)
        pat_bytes[8*k +: 8] = (k < len) ? alpha[$urandom_range(0, 2)]
                                        : bss_pkg::byte_t'($urandom_range(0, 255));

      pick = $urandom_range(0, 19);
      if (pick < 12)      limit = '0;
      else if (pick < 17) limit = $urandom_range(1, 80);
      else if (pick < 19) limit = '1;
      else                limit = $urandom();

      write_reg(bss_pkg::CFG_PATTERN_LOW, pat_bytes[63:0]);
      write_reg(bss_pkg::CFG_PATTERN_HIGH, pat_bytes[127:64]);
      write_reg(bss_pkg::CFG_PATTERN_LENGTH, bss_pkg::word_t'(len));
      write_reg(bss_pkg::CFG_SEARCH_LIMIT, {32'h0, limit});
      write_reg(bss_pkg::CFG_REPORT_ALL, bss_pkg::word_t'($urandom_range(0, 1)));

      sent = 0;
      while (sent < PHASE_LEN) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          run = (len >= 1 && len <= bss_pkg::MAX_PATTERN) ? len : 4;
          if (pick == 8) run = $urandom_range(1, run);   // broken copy
          for (int k = 0; k < run; k++) begin
            feed_byte((len >= 1 && len <= bss_pkg::MAX_PATTERN)
                      ? pat_bytes[8*k +: 8] : alpha[$urandom_range(0, 2)]);
            sent++;
          end
        end else begin
          feed_byte((pick < 17) ? alpha[$urandom_range(0, 2)]
                                : bss_pkg::byte_t'($urandom_range(0, 255)));
          sent++;
        end
      end
    end

    settle();
    if (errors == 0)
      $display("tb_byte_stream_substring_search: done, clean");
    else
      $display("tb_byte_stream_substring_search: done, errors");
    $finish;
  end

endmodule
